>>> rtl/trrt_pkg.sv
// Shared types, widths and sequence-compare helpers for the TCP receive range tracker.
package trrt_pkg;

    localparam int SEQ_W           = 32;
    localparam int LEN_W           = 16;
    localparam int READABLE_W      = 17;
    localparam int RUN_SLOTS_DEF   = 8;
    localparam int RING_BYTES_DEF  = 65536;

    typedef struct packed {
        logic [SEQ_W-1:0] head;
        logic [SEQ_W-1:0] tail;
    } run_t;

    // True when a is strictly after b in modulo 2^32 sequence space.
    function automatic logic seq_after(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[SEQ_W-1];
    endfunction

    // True when a is at or after b in modulo 2^32 sequence space.
    function automatic logic seq_at_or_after(input logic [SEQ_W-1:0] a,
                                             input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return !d[SEQ_W-1];
    endfunction

endpackage

>>> rtl/tcp_reassembly_range_tracker_core.sv
// Top level of the TCP receive range tracker: window clipping, run merging and absorbing.
// A consume transaction passes the consume and result states. A segment goes from prep
// straight to result when ignored or past the window, passes trim too when already received,
// walks the slot compares before the drop when the table is full, and otherwise walks the
// slot compares and slot moves of the merge and absorb walks; the one table read port sets
// this. Input is ready once the result is loaded; a result may wait at the output.
// Reset clears both cursors and the run count to zero; the run table is not cleared.
module tcp_reassembly_range_tracker_core #(
    parameter int RUN_SLOTS  = trrt_pkg::RUN_SLOTS_DEF,
    parameter int RING_BYTES = trrt_pkg::RING_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   cfg_data,        // initial_receive_next
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [47:0]   s_axis_tdata,    // sequence_req[31:0], length[47:32]
    input  logic [0:0]    s_axis_tuser,    // op[0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // write_start[31:0], write_skip[47:32], write_length[63:48], taken[79:64],
    // read_start[111:80], next_expected[143:112], readable[160:144], zero pad to 167
    output logic [167:0]  m_axis_tdata,
    output logic [1:0]    m_axis_tuser     // accepted[0], dropped_no_slot[1]
);

    localparam int SW    = trrt_pkg::SEQ_W;
    localparam int LW    = trrt_pkg::LEN_W;
    localparam int RW    = trrt_pkg::READABLE_W;
    localparam int IDX_W = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
    localparam int CNT_W = $clog2(RUN_SLOTS + 1);
    localparam int PAD_W = 168 - (3 * SW + 3 * LW + RW);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_PREP    = 10'b0000000010,
        ST_TRIM    = 10'b0000000100,
        ST_MERGE   = 10'b0000001000,
        ST_MOVE    = 10'b0000010000,
        ST_INSERT  = 10'b0000100000,
        ST_ABSORB  = 10'b0001000000,
        ST_AMOVE   = 10'b0010000000,
        ST_CONSUME = 10'b0100000000,
        ST_RESULT  = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [SW-1:0]      nio_reg, nio_next;
    logic [SW-1:0]      rc_reg, rc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               op_reg, op_next;
    logic [SW-1:0]      s_reg, s_next;
    logic [SW-1:0]      e_reg, e_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [LW-1:0]      skip_reg, skip_next;
    logic               acc_reg, acc_next;
    logic               drop_reg, drop_next;
    logic [SW-1:0]      wstart_reg, wstart_next;
    logic [LW-1:0]      wlen_reg, wlen_next;
    logic [LW-1:0]      taken_reg, taken_next;
    logic [SW-1:0]      rstart_reg, rstart_next;
    logic               out_valid_reg, out_valid_next;
    logic [167:0]       out_data_reg, out_data_next;
    logic [1:0]         out_user_reg, out_user_next;

    logic               tbl_wr_en;
    logic [IDX_W-1:0]   tbl_wr_addr;
    trrt_pkg::run_t     tbl_wr_run;
    logic [IDX_W-1:0]   tbl_rd_addr;
    trrt_pkg::run_t     tbl_rd_run;

    logic [SW-1:0]      seg_end;
    logic [SW-1:0]      win_end;
    logic [SW-1:0]      avail;
    logic [SW-1:0]      nio_gap;
    logic [LW-1:0]      take;
    logic               scan_live;

    trrt_run_table #(
        .SLOTS (RUN_SLOTS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_run  (tbl_wr_run),
        .rd_addr (tbl_rd_addr),
        .rd_run  (tbl_rd_run)
    );

    assign cfg_ready     = (state_reg == ST_IDLE);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    assign seg_end   = s_reg + SW'(len_reg);
    assign win_end   = rc_reg + SW'(RING_BYTES);
    assign avail     = nio_reg - rc_reg;
    assign nio_gap   = nio_reg - s_reg;
    assign take      = ({{(SW-LW){1'b0}}, len_reg} < avail) ? len_reg : avail[LW-1:0];
    assign scan_live = (idx_reg < cnt_reg);

    always_comb
    begin
        tbl_rd_addr = idx_reg[IDX_W-1:0];
        if ((state_reg == ST_MOVE) || (state_reg == ST_AMOVE))
        begin
            tbl_rd_addr = cnt_reg[IDX_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        nio_next       = nio_reg;
        rc_next        = rc_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        len_next       = len_reg;
        skip_next      = skip_reg;
        acc_next       = acc_reg;
        drop_next      = drop_reg;
        wstart_next    = wstart_reg;
        wlen_next      = wlen_reg;
        taken_next     = taken_reg;
        rstart_next    = rstart_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        tbl_wr_en      = 1'b0;
        tbl_wr_addr    = idx_reg[IDX_W-1:0];
        tbl_wr_run     = tbl_rd_run;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    nio_next = cfg_data;
                    rc_next  = cfg_data;
                    cnt_next = '0;
                end
                if (s_axis_tvalid)
                begin
                    op_next     = s_axis_tuser[0];
                    s_next      = s_axis_tdata[SW-1:0];
                    len_next    = s_axis_tdata[SW+LW-1:SW];
                    skip_next   = '0;
                    acc_next    = 1'b0;
                    drop_next   = 1'b0;
                    wstart_next = '0;
                    wlen_next   = '0;
                    taken_next  = '0;
                    rstart_next = '0;
                    state_next  = s_axis_tuser[0] ? ST_CONSUME : ST_PREP;
                end
            end
            ST_PREP:
            begin
                e_next = trrt_pkg::seq_after(seg_end, win_end) ? win_end : seg_end;
                if ((len_reg == '0) || trrt_pkg::seq_at_or_after(s_reg, win_end))
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                idx_next = '0;
                if (trrt_pkg::seq_at_or_after(nio_reg, e_reg))
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    if (trrt_pkg::seq_after(nio_reg, s_reg))
                    begin
                        skip_next   = nio_gap[LW-1:0];
                        s_next      = nio_reg;
                        wstart_next = nio_reg;
                        wlen_next   = LW'(e_reg - nio_reg);
                    end
                    else
                    begin
                        wstart_next = s_reg;
                        wlen_next   = LW'(e_reg - s_reg);
                    end
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (!scan_live)
                begin
                    state_next = ST_INSERT;
                end
                else if (trrt_pkg::seq_after(tbl_rd_run.head, e_reg) ||
                         trrt_pkg::seq_after(s_reg, tbl_rd_run.tail))
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    if (trrt_pkg::seq_after(s_reg, tbl_rd_run.head))
                    begin
                        s_next = tbl_rd_run.head;
                    end
                    if (trrt_pkg::seq_after(tbl_rd_run.tail, e_reg))
                    begin
                        e_next = tbl_rd_run.tail;
                    end
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                tbl_wr_en  = 1'b1;
                state_next = ST_MERGE;
            end
            ST_INSERT:
            begin
                if (cnt_reg >= CNT_W'(RUN_SLOTS))
                begin
                    drop_next   = 1'b1;
                    skip_next   = '0;
                    wstart_next = '0;
                    wlen_next   = '0;
                    state_next  = ST_RESULT;
                end
                else
                begin
                    tbl_wr_en       = 1'b1;
                    tbl_wr_addr     = cnt_reg[IDX_W-1:0];
                    tbl_wr_run.head = s_reg;
                    tbl_wr_run.tail = e_reg;
                    cnt_next        = cnt_reg + 1'b1;
                    acc_next        = 1'b1;
                    idx_next        = '0;
                    state_next      = ST_ABSORB;
                end
            end
            ST_ABSORB:
            begin
                if (!scan_live)
                begin
                    state_next = ST_RESULT;
                end
                else if (tbl_rd_run.head == nio_reg)
                begin
                    nio_next   = tbl_rd_run.tail;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_AMOVE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_AMOVE:
            begin
                tbl_wr_en  = 1'b1;
                idx_next   = '0;
                state_next = ST_ABSORB;
            end
            ST_CONSUME:
            begin
                rstart_next = rc_reg;
                rc_next     = rc_reg + SW'(take);
                taken_next  = take;
                state_next  = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{PAD_W{1'b0}}, avail[RW-1:0], nio_reg, rstart_reg,
                                      taken_reg, wlen_reg, skip_reg, wstart_reg};
                    out_user_next  = {drop_reg, acc_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nio_reg       <= '0;
            rc_reg        <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nio_reg       <= nio_next;
            rc_reg        <= rc_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        s_reg        <= s_next;
        e_reg        <= e_next;
        len_reg      <= len_next;
        skip_reg     <= skip_next;
        acc_reg      <= acc_next;
        drop_reg     <= drop_next;
        wstart_reg   <= wstart_next;
        wlen_reg     <= wlen_next;
        taken_reg    <= taken_next;
        rstart_reg   <= rstart_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

endmodule

>>> rtl/trrt_run_table.sv
// Table of stored out-of-order runs with one write port and one read port.
module trrt_run_table #(
    parameter int SLOTS = trrt_pkg::RUN_SLOTS_DEF,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  trrt_pkg::run_t    wr_run,
    input  logic [IDX_W-1:0]  rd_addr,
    output trrt_pkg::run_t    rd_run
);

    trrt_pkg::run_t slots_reg [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_addr] <= wr_run;
        end
    end

    assign rd_run = slots_reg[rd_addr];

endmodule

>>> tb/tb.sv
// Self-checking testbench for the TCP receive range tracker core.
`timescale 1ns / 1ps

module tb;

    localparam int          SEQ_W         = trrt_pkg::SEQ_W;
    localparam int          LEN_W         = trrt_pkg::LEN_W;
    localparam int          READABLE_W    = trrt_pkg::READABLE_W;
    localparam int          SLOTS         = trrt_pkg::RUN_SLOTS_DEF;
    localparam int          WINDOW        = trrt_pkg::RING_BYTES_DEF;
    localparam bit          OP_SEGMENT    = 1'b0;
    localparam bit          OP_CONSUME    = 1'b1;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          LONG_HOLD     = 400;
    localparam int          CYCLE_LIMIT   = 400000;

    typedef struct {
        bit              op;
        bit [SEQ_W-1:0]  seq;
        bit [LEN_W-1:0]  len;
    } rx_item_t;

    typedef struct {
        bit                   accepted;
        bit                   dropped_no_slot;
        bit [SEQ_W-1:0]       write_start;
        bit [LEN_W-1:0]       write_skip;
        bit [LEN_W-1:0]       write_length;
        bit [LEN_W-1:0]       taken;
        bit [SEQ_W-1:0]       read_start;
        bit [SEQ_W-1:0]       next_expected;
        bit [READABLE_W-1:0]  readable;
    } rx_result_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [31:0]   cfg_data = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [47:0]   s_axis_tdata = '0;
    logic [0:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [167:0]  m_axis_tdata;
    logic [1:0]    m_axis_tuser;

    rx_item_t      queued_items [$];
    rx_result_t    due_results [$];

    bit [SEQ_W-1:0] rcv_nxt;
    bit [SEQ_W-1:0] rd_ptr;
    bit [SEQ_W-1:0] run_head [SLOTS];
    bit [SEQ_W-1:0] run_tail [SLOTS];
    int             run_cnt;

    int  err_cnt = 0;
    int  result_no = 0;
    int  src_idle_pct = 29;
    int  snk_idle_pct = 29;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  cycle_cnt = 0;

    tcp_reassembly_range_tracker_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit is_later(bit [SEQ_W-1:0] a, bit [SEQ_W-1:0] b);
        bit [SEQ_W-1:0] d;
        d = a - b;
        return (d != 0) && (d < 32'h8000_0000);
    endfunction

    function automatic bit not_before(bit [SEQ_W-1:0] a, bit [SEQ_W-1:0] b);
        bit [SEQ_W-1:0] d;
        d = a - b;
        return d < 32'h8000_0000;
    endfunction

    function automatic void free_slot(int idx);
        run_cnt--;
        run_head[idx] = run_head[run_cnt];
        run_tail[idx] = run_tail[run_cnt];
    endfunction

    function automatic bit store_run(bit [SEQ_W-1:0] lo_in, bit [SEQ_W-1:0] hi_in);
        bit [SEQ_W-1:0] lo;
        bit [SEQ_W-1:0] hi;
        int             i;
        lo = lo_in;
        hi = hi_in;
        i = 0;
        while (i < run_cnt) begin
            if (is_later(run_head[i], hi) || is_later(lo, run_tail[i])) begin
                i++;
            end
            else begin
                if (is_later(lo, run_head[i]))
                    lo = run_head[i];
                if (is_later(run_tail[i], hi))
                    hi = run_tail[i];
                free_slot(i);
            end
        end
        if (run_cnt >= SLOTS)
            return 1'b0;
        run_head[run_cnt] = lo;
        run_tail[run_cnt] = hi;
        run_cnt++;
        return 1'b1;
    endfunction

    function automatic void absorb_in_order();
        int i;
        i = 0;
        while (i < run_cnt) begin
            if (run_head[i] != rcv_nxt) begin
                i++;
            end
            else begin
                rcv_nxt = run_tail[i];
                free_slot(i);
                i = 0;
            end
        end
    endfunction

    function automatic rx_result_t track_item(rx_item_t it);
        rx_result_t     r;
        bit [SEQ_W-1:0] lo;
        bit [SEQ_W-1:0] hi;
        bit [SEQ_W-1:0] win_end;
        bit [SEQ_W-1:0] skip;
        bit [SEQ_W-1:0] span;
        bit [SEQ_W-1:0] avail;
        bit [SEQ_W-1:0] take;
        r = '{default: 0};
        if (it.op == OP_SEGMENT) begin
            if (it.len != 0) begin
                lo = it.seq;
                hi = it.seq + 32'(it.len);
                win_end = rd_ptr + 32'(WINDOW);
                skip = 0;
                if (is_later(hi, win_end))
                    hi = win_end;
                if (!not_before(lo, win_end) && !not_before(rcv_nxt, hi)) begin
                    if (is_later(rcv_nxt, lo)) begin
                        skip = rcv_nxt - lo;
                        lo = rcv_nxt;
                    end
                    if (store_run(lo, hi)) begin
                        span = hi - lo;
                        r.accepted = 1'b1;
                        r.write_start = lo;
                        r.write_skip = skip[LEN_W-1:0];
                        r.write_length = span[LEN_W-1:0];
                        absorb_in_order();
                    end
                    else begin
                        r.dropped_no_slot = 1'b1;
                    end
                end
            end
        end
        else begin
            avail = rcv_nxt - rd_ptr;
            take = (32'(it.len) < avail) ? 32'(it.len) : avail;
            r.read_start = rd_ptr;
            rd_ptr = rd_ptr + take;
            r.taken = take[LEN_W-1:0];
        end
        r.next_expected = rcv_nxt;
        avail = rcv_nxt - rd_ptr;
        r.readable = avail[READABLE_W-1:0];
        return r;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %h, expected %h",
                                   result_no, name, got, want));
    endtask

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                due_results.push_back(track_item(queued_items.pop_front()));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (queued_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {queued_items[0].len, queued_items[0].seq};
                    s_axis_tuser  <= queued_items[0].op;
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        rx_result_t want;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    report_error("result transaction with no expectation pending");
                end
                else begin
                    want = due_results.pop_front();
                    check_field("accepted", 32'(m_axis_tuser[0]), 32'(want.accepted));
                    check_field("dropped_no_slot", 32'(m_axis_tuser[1]),
                                32'(want.dropped_no_slot));
                    check_field("write_start", m_axis_tdata[31:0], want.write_start);
                    check_field("write_skip", 32'(m_axis_tdata[47:32]), 32'(want.write_skip));
                    check_field("write_length", 32'(m_axis_tdata[63:48]),
                                32'(want.write_length));
                    check_field("taken", 32'(m_axis_tdata[79:64]), 32'(want.taken));
                    check_field("read_start", m_axis_tdata[111:80], want.read_start);
                    check_field("next_expected", m_axis_tdata[143:112], want.next_expected);
                    check_field("readable", 32'(m_axis_tdata[160:144]), 32'(want.readable));
                end
                result_no++;
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (hold_req != hold_seen) begin
            hold_left <= LONG_HOLD;
            hold_seen <= hold_req;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_item(bit op, bit [SEQ_W-1:0] seq, bit [LEN_W-1:0] len);
        rx_item_t it;
        it.op = op;
        it.seq = seq;
        it.len = len;
        queued_items.push_back(it);
    endtask

    task automatic load_start_seq(bit [SEQ_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rcv_nxt = value;
        rd_ptr = value;
        run_cnt = 0;
    endtask

    task automatic wait_drained();
        while (queued_items.size() != 0 || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_traffic(int count);
        bit [SEQ_W-1:0] pos;
        bit [SEQ_W-1:0] rc;
        bit [LEN_W-1:0] ln;
        int             pick;
        pos = rcv_nxt;
        rc = rd_ptr;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                ln = LEN_W'($urandom_range(1, 1500));
                queue_item(OP_SEGMENT, pos, ln);
                pos = pos + 32'(ln);
            end
            else if (pick < 58) begin
                queue_item(OP_SEGMENT, pos + $urandom_range(1, 30000),
                           LEN_W'($urandom_range(1, 2000)));
            end
            else if (pick < 66) begin
                queue_item(OP_SEGMENT, pos - $urandom_range(0, 3000),
                           LEN_W'($urandom_range(1, 4000)));
            end
            else if (pick < 84) begin
                if ($urandom_range(3) == 0)
                    queue_item(OP_CONSUME, $urandom, LEN_W'($urandom_range(0, 65535)));
                else
                    queue_item(OP_CONSUME, $urandom, LEN_W'($urandom_range(0, 4000)));
            end
            else if (pick < 92) begin
                queue_item(1'($urandom_range(1)), $urandom, LEN_W'($urandom_range(0, 65535)));
            end
            else if (pick < 95) begin
                queue_item(OP_SEGMENT, pos, 0);
            end
            else begin
                queue_item(OP_SEGMENT, rc + 32'(WINDOW) - $urandom_range(0, 3000),
                           LEN_W'($urandom_range(1, 6000)));
            end
        end
    endtask

    initial
    begin : stimulus
        bit [SEQ_W-1:0] base;
        bit [SEQ_W-1:0] phase_seq [5];
        int             phase;
        int             burst;
        int             i;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        base = 32'hFFFF_F000;
        load_start_seq(base);
        queue_item(OP_CONSUME, 0, 100);
        queue_item(OP_SEGMENT, base, 0);
        queue_item(OP_SEGMENT, base, 100);
        queue_item(OP_SEGMENT, base, 50);
        queue_item(OP_SEGMENT, base + 50, 100);
        queue_item(OP_SEGMENT, base + 70000, 10);
        queue_item(OP_SEGMENT, base + 65000, 1000);
        for (i = 1; i <= 7; i++)
            queue_item(OP_SEGMENT, base + 1000 * i, 100);
        queue_item(OP_SEGMENT, base + 20000, 10);
        queue_item(OP_SEGMENT, base + 1100, 100);
        queue_item(OP_SEGMENT, base + 1200, 1900);
        queue_item(OP_SEGMENT, base + 150, 850);
        queue_item(OP_CONSUME, 0, 16'hFFFF);
        queue_item(OP_CONSUME, 0, 0);
        queue_item(OP_SEGMENT, base + 3100, 16'hFFFF);
        queue_item(OP_SEGMENT, 32'hFFFF_FFFF, 16'hFFFF);
        queue_item(OP_CONSUME, 32'hFFFF_FFFF, 16'hFFFF);
        queue_item(OP_CONSUME, 0, 16'hFFFF);
        queue_item(OP_SEGMENT, 0, 1);
        wait_drained();

        phase_seq = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FF00, 32'h8000_0000, $urandom};
        for (phase = 0; phase < 5; phase++) begin
            load_start_seq(phase_seq[phase]);
            src_idle_pct = (phase == 2) ? 0 : 29;
            snk_idle_pct = (phase == 2) ? 0 : 29;
            for (burst = 0; burst < 4; burst++) begin
                queue_traffic(56);
                if (burst == 0 && (phase == 1 || phase == 3))
                    hold_req++;
                wait_drained();
            end
        end

        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
